[hw/rtl/swet_pkg.sv]
package swet_pkg;

    localparam int POS_W       = 32;
    localparam int CFG_W       = 7;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int CFG_RESET_WINDOW_LENGTH = 10;

    localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LENGTH = '0;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

endpackage

[hw/rtl/swet_cell.sv]
module swet_cell import swet_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int LEN_W        = 7,
    parameter int CELL_INDEX   = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic        [POS_W-1:0]        i_pos,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample,
    output logic        [POS_W-1:0]        o_pos,
    input  logic        [LEN_W-1:0]        i_len,
    input  logic                           i_tok_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_tok_max,
    input  logic        [POS_W-1:0]        i_tok_max_pos,
    input  logic signed [SAMPLE_WIDTH-1:0] i_tok_min,
    input  logic        [POS_W-1:0]        i_tok_min_pos,
    output logic                           o_tok_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_tok_max,
    output logic        [POS_W-1:0]        o_tok_max_pos,
    output logic signed [SAMPLE_WIDTH-1:0] o_tok_min,
    output logic        [POS_W-1:0]        o_tok_min_pos
);

    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic        [POS_W-1:0]        r_pos;
    logic                           r_tok_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_tok_max;
    logic        [POS_W-1:0]        r_tok_max_pos;
    logic signed [SAMPLE_WIDTH-1:0] r_tok_min;
    logic        [POS_W-1:0]        r_tok_min_pos;
    logic signed [SAMPLE_WIDTH-1:0] n_tok_max;
    logic        [POS_W-1:0]        n_tok_max_pos;
    logic signed [SAMPLE_WIDTH-1:0] n_tok_min;
    logic        [POS_W-1:0]        n_tok_min_pos;
    logic                           w_include;

    // This cell holds an older sample than every cell before it, so it wins ties.
    assign w_include = LEN_W'(CELL_INDEX) < i_len;

    always_comb begin
        n_tok_max     = i_tok_max;
        n_tok_max_pos = i_tok_max_pos;
        n_tok_min     = i_tok_min;
        n_tok_min_pos = i_tok_min_pos;
        if (CELL_INDEX == 0) begin
            n_tok_max     = r_sample;
            n_tok_max_pos = r_pos;
            n_tok_min     = r_sample;
            n_tok_min_pos = r_pos;
        end else if (w_include) begin
            if (r_sample >= i_tok_max) begin
                n_tok_max     = r_sample;
                n_tok_max_pos = r_pos;
            end
            if (r_sample <= i_tok_min) begin
                n_tok_min     = r_sample;
                n_tok_min_pos = r_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
            r_pos    <= i_pos;
        end
        r_tok_max     <= n_tok_max;
        r_tok_max_pos <= n_tok_max_pos;
        r_tok_min     <= n_tok_min;
        r_tok_min_pos <= n_tok_min_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    assign o_sample      = r_sample;
    assign o_pos         = r_pos;
    assign o_tok_valid   = r_tok_valid;
    assign o_tok_max     = r_tok_max;
    assign o_tok_max_pos = r_tok_max_pos;
    assign o_tok_min     = r_tok_min;
    assign o_tok_min_pos = r_tok_min_pos;

endmodule

[hw/rtl/sliding_window_extremum_tracker.sv]
// Channel  | Handshake            | Beat contents
// input    | i_valid / o_stall    | i_sample, i_restart
// output   | o_valid / i_stall    | o_window_max, o_window_min, o_max_position, o_min_position
// config   | APB psel / penable   | window_length at byte address 0
// A beat is accepted in the idle state and shifts into a row of WINDOW_MAX cells.
// A comparison token then walks the row, one cell per cycle; the next beat is
// taken only after the token has left the row and its result has been loaded
// into the output register.
// The output register lets a new beat in while a result still waits.
// Reset is synchronous and active low; window_length resets to 10.
module sliding_window_extremum_tracker import swet_pkg::*; #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_restart,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_window_max,
    output logic signed [SAMPLE_WIDTH-1:0] o_window_min,
    output logic        [POS_W-1:0]        o_max_position,
    output logic        [POS_W-1:0]        o_min_position,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [APB_ADDR_W-1:0]   paddr,
    input  logic        [APB_DATA_W-1:0]   pwdata,
    output logic        [APB_DATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int CW    = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    t_state                         r_state;
    logic        [CFG_W-1:0]        r_wl;
    logic        [LEN_W-1:0]        r_filled;
    logic        [POS_W-1:0]        r_pos;
    logic                           r_inject;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_max;
    logic signed [SAMPLE_WIDTH-1:0] r_out_min;
    logic        [POS_W-1:0]        r_out_max_pos;
    logic        [POS_W-1:0]        r_out_min_pos;
    logic signed [SAMPLE_WIDTH-1:0] r_hold_max;
    logic signed [SAMPLE_WIDTH-1:0] r_hold_min;
    logic        [POS_W-1:0]        r_hold_max_pos;
    logic        [POS_W-1:0]        r_hold_min_pos;

    logic        [LEN_W-1:0]        n_filled;
    logic        [POS_W-1:0]        n_pos;
    logic        [LEN_W-1:0]        w_base_filled;
    logic        [POS_W-1:0]        w_base_pos;
    logic        [CW-1:0]           w_wl_x;
    logic        [CW-1:0]           w_wl_eff;
    logic        [LEN_W-1:0]        w_len;
    logic                           w_in_acc;
    logic                           w_slot_free;
    logic                           w_exit;
    logic                           w_out_load;
    logic                           w_cfg_wr;

    logic signed [SAMPLE_WIDTH-1:0] w_samp    [WINDOW_MAX+1];
    logic        [POS_W-1:0]        w_spos    [WINDOW_MAX+1];
    logic        [WINDOW_MAX:0]     w_tok_v;
    logic signed [SAMPLE_WIDTH-1:0] w_tok_max [WINDOW_MAX+1];
    logic        [POS_W-1:0]        w_tok_maxp[WINDOW_MAX+1];
    logic signed [SAMPLE_WIDTH-1:0] w_tok_min [WINDOW_MAX+1];
    logic        [POS_W-1:0]        w_tok_minp[WINDOW_MAX+1];

    assign pready   = 1'b1;
    assign prdata   = APB_DATA_W'(r_wl);
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH);

    assign o_stall     = (r_state != ST_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_exit      = w_tok_v[WINDOW_MAX];
    assign w_out_load  = w_slot_free &&
                         (((r_state == ST_SCAN) && w_exit) || (r_state == ST_HOLD));

    always_comb begin
        w_base_pos    = i_restart ? '0 : r_pos;
        w_base_filled = i_restart ? '0 : r_filled;
        n_pos         = (w_base_pos == {POS_W{1'b1}}) ? w_base_pos : w_base_pos + 1'b1;
        n_filled      = (w_base_filled == LEN_W'(WINDOW_MAX)) ? w_base_filled
                                                              : w_base_filled + 1'b1;
        w_wl_x = CW'(r_wl);
        if (w_wl_x == '0) begin
            w_wl_eff = CW'(1);
        end else if (w_wl_x > CW'(WINDOW_MAX)) begin
            w_wl_eff = CW'(WINDOW_MAX);
        end else begin
            w_wl_eff = w_wl_x;
        end
        w_len = (w_wl_eff > CW'(r_filled)) ? r_filled : LEN_W'(w_wl_eff);
    end

    assign w_samp[0]     = i_sample;
    assign w_spos[0]     = n_pos;
    assign w_tok_v[0]    = r_inject;
    assign w_tok_max[0]  = '0;
    assign w_tok_maxp[0] = '0;
    assign w_tok_min[0]  = '0;
    assign w_tok_minp[0] = '0;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swet_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .LEN_W        (LEN_W),
            .CELL_INDEX   (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (w_in_acc),
            .i_sample      (w_samp[g]),
            .i_pos         (w_spos[g]),
            .o_sample      (w_samp[g+1]),
            .o_pos         (w_spos[g+1]),
            .i_len         (w_len),
            .i_tok_valid   (w_tok_v[g]),
            .i_tok_max     (w_tok_max[g]),
            .i_tok_max_pos (w_tok_maxp[g]),
            .i_tok_min     (w_tok_min[g]),
            .i_tok_min_pos (w_tok_minp[g]),
            .o_tok_valid   (w_tok_v[g+1]),
            .o_tok_max     (w_tok_max[g+1]),
            .o_tok_max_pos (w_tok_maxp[g+1]),
            .o_tok_min     (w_tok_min[g+1]),
            .o_tok_min_pos (w_tok_minp[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wl        <= CFG_W'(CFG_RESET_WINDOW_LENGTH);
            r_filled    <= '0;
            r_pos       <= '0;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inject    <= w_in_acc;
            r_out_valid <= w_out_load || (r_out_valid && i_stall);
            if (w_cfg_wr) begin
                r_wl <= pwdata[CFG_W-1:0];
            end
            if (w_in_acc) begin
                r_filled <= n_filled;
                r_pos    <= n_pos;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_exit) begin
                        if (w_slot_free) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (w_slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && w_exit) begin
            r_hold_max     <= w_tok_max[WINDOW_MAX];
            r_hold_min     <= w_tok_min[WINDOW_MAX];
            r_hold_max_pos <= w_tok_maxp[WINDOW_MAX];
            r_hold_min_pos <= w_tok_minp[WINDOW_MAX];
            if (w_slot_free) begin
                r_out_max     <= w_tok_max[WINDOW_MAX];
                r_out_min     <= w_tok_min[WINDOW_MAX];
                r_out_max_pos <= w_tok_maxp[WINDOW_MAX];
                r_out_min_pos <= w_tok_minp[WINDOW_MAX];
            end
        end else if (r_state == ST_HOLD && w_slot_free) begin
            r_out_max     <= r_hold_max;
            r_out_min     <= r_hold_min;
            r_out_max_pos <= r_hold_max_pos;
            r_out_min_pos <= r_hold_min_pos;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_window_max   = r_out_max;
    assign o_window_min   = r_out_min;
    assign o_max_position = r_out_max_pos;
    assign o_min_position = r_out_min_pos;

`ifndef ASSERT_OFF
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_v))
        else $error("More than one comparison token in the cell row.");

    a_exit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit |-> (r_state == ST_SCAN))
        else $error("Token left the cell row outside the scan state.");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_SCAN) && r_inject)
        else $error("Accepted beat did not start a scan.");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_max >= r_out_min) && (r_out_max_pos != '0) &&
                        (r_out_min_pos != '0))
        else $error("Result beat has inconsistent extrema or a zero position.");
`endif

endmodule

[dv/sliding_window_extremum_tracker_tb.sv]
module sliding_window_extremum_tracker_tb;
    import swet_pkg::*;

    localparam int WMAX        = 64;
    localparam int IDX_W       = $clog2(WMAX);
    localparam int SW          = 32;
    localparam int DIR_N       = 21;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 123;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [SW-1:0]    wmax;
        logic signed [SW-1:0]    wmin;
        logic        [POS_W-1:0] pmax;
        logic        [POS_W-1:0] pmin;
    } t_extrema;

    typedef struct {
        logic [CFG_W-1:0]     wl;
        logic signed [SW-1:0] sample;
        logic                 restart;
        bit                   typed;
        t_extrema             res;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic                  o_stall;
    logic signed [SW-1:0]  i_sample  = '0;
    logic                  i_restart = 1'b0;
    logic                  o_valid;
    logic                  i_stall   = 1'b0;
    logic signed [SW-1:0]  o_window_max;
    logic signed [SW-1:0]  o_window_min;
    logic [POS_W-1:0]      o_max_position;
    logic [POS_W-1:0]      o_min_position;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sliding_window_extremum_tracker #(
        .WINDOW_MAX  (WMAX),
        .SAMPLE_WIDTH(SW)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_window_max  (o_window_max),
        .o_window_min  (o_window_min),
        .o_max_position(o_max_position),
        .o_min_position(o_min_position),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    logic signed [SW-1:0] win_val [WMAX];
    logic [POS_W-1:0]     win_pos [WMAX];
    logic [IDX_W-1:0]     wr_ptr   = '0;
    int unsigned          fill_cnt = 0;
    logic [POS_W-1:0]     ser_pos  = '0;
    logic [CFG_W-1:0]     cur_wl   = CFG_W'(CFG_RESET_WINDOW_LENGTH);

    t_extrema pending_extrema [$];

    int  cycle_count   = 0;
    int  fail_count    = 0;
    int  beats_sent    = 0;
    int  beats_checked = 0;
    int  restarts_sent = 0;
    int  cfg_writes    = 0;
    bit  hold_req      = 1'b0;

    t_dir_row dir_rows [0:DIR_N-1] = '{
        '{7'd10,  32'sh7FFFFFFF, 1'b1, 1'b1, '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'd1, 32'd1}},
        '{7'd10,  32'sh80000000, 1'b0, 1'b1, '{32'sh7FFFFFFF, 32'sh80000000, 32'd1, 32'd2}},
        '{7'd10,  32'sd0,        1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd10,  32'sh7FFFFFFF, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd10,  32'sh80000000, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd10,  32'sd3,        1'b1, 1'b1, '{32'sd3, 32'sd3, 32'd1, 32'd1}},
        '{7'd10,  32'sd3,        1'b0, 1'b1, '{32'sd3, 32'sd3, 32'd1, 32'd1}},
        '{7'd10,  -32'sd1,       1'b0, 1'b1, '{32'sd3, -32'sd1, 32'd1, 32'd3}},
        '{7'd1,   32'sd5,        1'b0, 1'b1, '{32'sd5, 32'sd5, 32'd4, 32'd4}},
        '{7'd1,   -32'sd7,       1'b0, 1'b1, '{-32'sd7, -32'sd7, 32'd5, 32'd5}},
        '{7'd0,   32'sd9,        1'b0, 1'b1, '{32'sd9, 32'sd9, 32'd6, 32'd6}},
        '{7'd0,   32'sd8,        1'b1, 1'b1, '{32'sd8, 32'sd8, 32'd1, 32'd1}},
        '{7'd127, 32'sh40000000, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd127, -32'sd5,       1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd64,  32'sd0,        1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd64,  32'sh7FFFFFFF, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd65,  32'sd1,        1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd65,  32'sh80000000, 1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd2,   32'sd4,        1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd2,   32'sd4,        1'b0, 1'b0, '{0, 0, 0, 0}},
        '{7'd2,   -32'sd4,       1'b0, 1'b0, '{0, 0, 0, 0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic t_extrema predict_extrema(input logic signed [SW-1:0] s,
                                                 input logic rs);
        t_extrema             r;
        int unsigned          len;
        int unsigned          k;
        logic [IDX_W-1:0]     idx;
        logic signed [SW-1:0] v;
        r = '{0, 0, 0, 0};
        if (rs) begin
            fill_cnt = 0;
            ser_pos  = '0;
        end
        if (ser_pos != '1) begin
            ser_pos = ser_pos + 1'b1;
        end
        win_val[wr_ptr] = s;
        win_pos[wr_ptr] = ser_pos;
        wr_ptr = wr_ptr + 1'b1;
        if (fill_cnt < WMAX) begin
            fill_cnt++;
        end
        len = 32'(cur_wl);
        if (len == 0) begin
            len = 1;
        end
        if (len > WMAX) begin
            len = WMAX;
        end
        if (len > fill_cnt) begin
            len = fill_cnt;
        end
        for (k = len; k > 0; k--) begin
            idx = wr_ptr - IDX_W'(k);
            v   = win_val[idx];
            if (k == len) begin
                r.wmax = v;
                r.wmin = v;
                r.pmax = win_pos[idx];
                r.pmin = win_pos[idx];
            end else begin
                if (v > r.wmax) begin
                    r.wmax = v;
                    r.pmax = win_pos[idx];
                end
                if (v < r.wmin) begin
                    r.wmin = v;
                    r.pmin = win_pos[idx];
                end
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic signed [SW-1:0] s, input logic rs,
                             input bit typed, input t_extrema fixed_res);
        t_extrema r;
        i_valid   <= 1'b1;
        i_sample  <= s;
        i_restart <= rs;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        r = predict_extrema(s, rs);
        if (typed) begin
            r = fixed_res;
        end
        pending_extrema = {pending_extrema, r};
        beats_sent++;
        if (rs) begin
            restarts_sent++;
        end
    endtask

    task automatic settle_idle();
        i_valid <= 1'b0;
        while (pending_extrema.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window_length(input logic [CFG_W-1:0] wl);
        logic [APB_DATA_W-1:0] data;
        data = $urandom;
        data[CFG_W-1:0] = wl;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_LENGTH, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_wl = wl;
        cfg_writes++;
    endtask

    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 50;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: begin
                        i_stall <= 1'b0;
                    end
                    1: begin
                        i_stall <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_stall <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        i_stall <= (tick % 7 < 3);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_extrema e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_extrema.size() == 0) begin
                $error("result beat with no expectation pending");
                fail_count++;
            end else begin
                e = pending_extrema.pop_front();
                beats_checked++;
                if (o_window_max !== e.wmax) begin
                    $error("window_max: expected %0d, got %0d", e.wmax, o_window_max);
                    fail_count++;
                end
                if (o_window_min !== e.wmin) begin
                    $error("window_min: expected %0d, got %0d", e.wmin, o_window_min);
                    fail_count++;
                end
                if (o_max_position !== e.pmax) begin
                    $error("max_position: expected %0d, got %0d", e.pmax, o_max_position);
                    fail_count++;
                end
                if (o_min_position !== e.pmin) begin
                    $error("min_position: expected %0d, got %0d", e.pmin, o_min_position);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0]     phase_wl [PHASES];
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] ramp;
        logic                 rs;
        int unsigned          style;
        int unsigned          burst_left;
        int unsigned          gap;
        t_extrema             none;
        none     = '{0, 0, 0, 0};
        phase_wl = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd5, 7'd65, 7'd2, 7'd0, 7'd63, 7'd0};
        phase_wl[7] = CFG_W'($urandom_range(0, 127));
        phase_wl[9] = CFG_W'($urandom_range(0, 127));
        style      = 0;
        burst_left = 1;
        ramp       = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (dir_rows[i].wl != cur_wl) begin
                settle_idle();
                write_window_length(dir_rows[i].wl);
            end
            send_item(dir_rows[i].sample, dir_rows[i].restart, dir_rows[i].typed,
                      dir_rows[i].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle_idle();
            write_window_length(phase_wl[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == 30) begin
                    hold_req = 1'b1;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    style      = $urandom_range(0, 4);
                    ramp       = $urandom;
                end
                case (style)
                    0: s = $urandom;
                    1: s = $signed($urandom_range(0, 4)) - 2;
                    2: begin
                        ramp = ramp - $signed($urandom_range(1, 3));
                        s    = ramp;
                    end
                    3: begin
                        ramp = ramp + $signed($urandom_range(1, 3));
                        s    = ramp;
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: s = 32'sh7FFFFFFF;
                            1: s = 32'sh80000000;
                            2: s = '0;
                            default: s = -32'sd1;
                        endcase
                    end
                endcase
                rs = ($urandom_range(0, 99) < 2);
                send_item(s, rs, 1'b0, none);
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 3) != 0) begin
                    gap = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                      : $urandom_range(9, 150);
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        settle_idle();
        repeat (WMAX + 8) @(posedge i_clk);
        $display("Sent %0d sample beats (%0d with restart) under %0d window settings.",
                 beats_sent, restarts_sent, cfg_writes);
        $display("Checked %0d result beats; %0d mismatches.", beats_checked, fail_count);
        if (fail_count == 0 && pending_extrema.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
